>>> rtl/sliding_window_peak_to_peak_top_macros.svh
// assertion helpers shared by swpp_spread and the top module
// both expect clk and arst_n in the enclosing module
`ifndef SLIDING_WINDOW_PEAK_TO_PEAK_TOP_MACROS_SVH
`define SLIDING_WINDOW_PEAK_TO_PEAK_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define SWPP_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define SWPP_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

>>> rtl/swpp_pkg.sv
package swpp_pkg;

	// default sizes
	localparam int WINDOW_MAX  = 256;
	localparam int SAMPLE_BITS = 32;

	// fixed field widths
	localparam int CFG_W    = 9;
	localparam int COUNT_W  = 9;
	localparam int SPREAD_W = 32;

	// count saturates here, enough to show a full window is present
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 9'd511;
	localparam logic [CFG_W-1:0]   WINDOW_RESET = 9'd1;

	// per-transaction control that travels down the pipeline
	typedef struct packed {
		logic valid;
		logic last;
		logic window_ok;
	} swpp_ctrl_t;

endpackage

>>> rtl/swpp_cell.sv
module swpp_cell #(
	parameter int SAMPLE_BITS = swpp_pkg::SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [SAMPLE_BITS-1:0] prev_hi,
	input  logic signed [SAMPLE_BITS-1:0] prev_lo,
	output logic signed [SAMPLE_BITS-1:0] hi,
	output logic signed [SAMPLE_BITS-1:0] lo
);

	logic signed [SAMPLE_BITS-1:0] hi_q;
	logic signed [SAMPLE_BITS-1:0] lo_q;

	// running max/min of one more sample than the neighbor holds
	always_ff @(posedge clk) begin
		if (en) begin
			hi_q <= (prev_hi > sample) ? prev_hi : sample;
			lo_q <= (prev_lo < sample) ? prev_lo : sample;
		end
	end

	assign hi = hi_q;
	assign lo = lo_q;

endmodule

>>> rtl/swpp_spread.sv
module swpp_spread #(
	parameter int SAMPLE_BITS = swpp_pkg::SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  swpp_pkg::swpp_ctrl_t                 ctrl_s2,
	input  logic signed [SAMPLE_BITS-1:0]        hi_s2,
	input  logic signed [SAMPLE_BITS-1:0]        lo_s2,
	output logic                                 out_valid,
	output logic [swpp_pkg::SPREAD_W-1:0]        widest_spread
);

	`include "sliding_window_peak_to_peak_top_macros.svh"

	localparam int EXT_W = SAMPLE_BITS + swpp_pkg::SPREAD_W;

	logic [SAMPLE_BITS-1:0]            diff;
	logic [EXT_W-1:0]                  diff_ext;
	logic [swpp_pkg::SPREAD_W-1:0]     spread;
	logic [swpp_pkg::SPREAD_W-1:0]     best_q;
	logic [swpp_pkg::SPREAD_W-1:0]     best_next;
	logic                              out_valid_q;
	logic [swpp_pkg::SPREAD_W-1:0]     widest_spread_q;

	// window spread, max never below min so the difference is non-negative
	assign diff     = SAMPLE_BITS'(hi_s2 - lo_s2);
	assign diff_ext = EXT_W'(diff);
	assign spread   = diff_ext[swpp_pkg::SPREAD_W-1:0];

	// best spread including this window
	always_comb begin
		best_next = best_q;
		if (ctrl_s2.valid && ctrl_s2.window_ok && (spread > best_q)) begin
			best_next = spread;
		end
	end

	// best tracking, cleared after a record ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (adv && ctrl_s2.valid) begin
			best_q <= ctrl_s2.last ? '0 : best_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctrl_s2.valid && ctrl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctrl_s2.valid && ctrl_s2.last) begin
			widest_spread_q <= best_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign widest_spread = widest_spread_q;

	`SWPP_ASSERT_NEXT(a_last_emits, adv && ctrl_s2.valid && ctrl_s2.last, out_valid_q, "record end without result")
	`SWPP_ASSERT_NEXT(a_best_cleared, adv && ctrl_s2.valid && ctrl_s2.last, best_q == '0, "best spread not cleared")
	`SWPP_ASSERT_NEXT(a_result_held, !adv, out_valid_q && $stable(widest_spread_q), "held result changed")

endmodule

>>> rtl/sliding_window_peak_to_peak_top.sv
// Sliding window peak-to-peak: takes one signed sample per transaction, framed into records
// by last, and for every full window of the last window_size samples of the record tracks the
// largest max minus min; the transaction carrying last returns that spread (0 if no window
// closed) and starts a new record. A sample is taken every cycle while the output is not
// stalled; the result passes the stage 1, stage 2 and output registers. A row of WINDOW_MAX
// cells, each holding the max and min of one more recent sample than its neighbor, updates on
// every accepted sample; a tap on that row picks the window, and a registered subtract and
// compare stage keeps the best spread. A full output register held by out_stall stalls the
// whole pipe. Window sizes of 0 act as 1, and sizes above WINDOW_MAX never close a window.
module sliding_window_peak_to_peak_top #(
	parameter int WINDOW_MAX  = swpp_pkg::WINDOW_MAX,
	parameter int SAMPLE_BITS = swpp_pkg::SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [swpp_pkg::CFG_W-1:0]           cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [swpp_pkg::SPREAD_W-1:0]        widest_spread
);

	`include "sliding_window_peak_to_peak_top_macros.svh"

	localparam int TAP_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	logic [swpp_pkg::CFG_W-1:0]      window_size_q;
	logic [swpp_pkg::COUNT_W-1:0]    sample_count_q;
	logic [swpp_pkg::COUNT_W-1:0]    count_next;
	logic [swpp_pkg::CFG_W-1:0]      w_eff;
	logic                            w_fits;
	logic                            window_ok;
	logic                            adv;
	logic                            accept;

	logic signed [SAMPLE_BITS-1:0]   hi_taps [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0]   lo_taps [WINDOW_MAX];

	swpp_pkg::swpp_ctrl_t            ctrl_s1;
	swpp_pkg::swpp_ctrl_t            ctrl_s2;
	logic [TAP_W-1:0]                tap_s1;
	logic signed [SAMPLE_BITS-1:0]   hi_s2;
	logic signed [SAMPLE_BITS-1:0]   lo_s2;

	// pipe moves unless a finished result is held by the sink
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	// window size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swpp_pkg::WINDOW_RESET;
		end else if (cfg_wr_en) begin
			window_size_q <= cfg_wr_data;
		end
	end

	// window check for the incoming sample
	always_comb begin
		w_eff      = (window_size_q == '0) ? swpp_pkg::CFG_W'(1) : window_size_q;
		count_next = (sample_count_q == swpp_pkg::COUNT_LIMIT) ? sample_count_q
			: sample_count_q + swpp_pkg::COUNT_W'(1);
		w_fits     = (32'(w_eff) <= 32'(WINDOW_MAX));
		window_ok  = w_fits && (count_next >= w_eff);
	end

	// samples seen in the record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
		end else if (accept) begin
			sample_count_q <= last ? '0 : count_next;
		end
	end

	// row of max/min cells, cell k covers the k+1 newest samples
	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		if (k == 0) begin : g_head
			swpp_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
				.clk     (clk),
				.en      (accept),
				.sample  (sample),
				.prev_hi (sample),
				.prev_lo (sample),
				.hi      (hi_taps[k]),
				.lo      (lo_taps[k])
			);
		end else begin : g_body
			swpp_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
				.clk     (clk),
				.en      (accept),
				.sample  (sample),
				.prev_hi (hi_taps[k-1]),
				.prev_lo (lo_taps[k-1]),
				.hi      (hi_taps[k]),
				.lo      (lo_taps[k])
			);
		end
	end

	// stage 1 and 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s1.valid     <= in_valid;
			ctrl_s1.last      <= last;
			ctrl_s1.window_ok <= window_ok;
			ctrl_s2           <= ctrl_s1;
		end
	end

	// tap index and window select
	always_ff @(posedge clk) begin
		if (accept) begin
			tap_s1 <= TAP_W'(w_eff - swpp_pkg::CFG_W'(1));
		end
		if (adv && ctrl_s1.valid) begin
			hi_s2 <= hi_taps[tap_s1];
			lo_s2 <= lo_taps[tap_s1];
		end
	end

	swpp_spread #(.SAMPLE_BITS(SAMPLE_BITS)) u_spread (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.ctrl_s2       (ctrl_s2),
		.hi_s2         (hi_s2),
		.lo_s2         (lo_s2),
		.out_valid     (out_valid),
		.widest_spread (widest_spread)
	);

	`SWPP_ASSERT_NEXT(a_count_clear, accept && last, sample_count_q == '0, "count not cleared at record end")
	`SWPP_ASSERT_NEXT(a_head_cell, accept, hi_taps[0] == lo_taps[0], "head cell max and min differ")
	`SWPP_ASSERT_NOW(a_window_order, ctrl_s2.valid && ctrl_s2.window_ok, hi_s2 >= lo_s2, "window max below min")

endmodule
